[sv/dwa_pkg.sv]
// dwa_pkg: shared types, codes and helpers of the dfa word acceptor
// used by dwa_ctrl, dwa_datapath, dfa_word_acceptor and dwa_checker
// no dependencies
package dwa_pkg;

  localparam int DEF_NUM_STATES  = 16;
  localparam int DEF_NUM_SYMBOLS = 16;

  localparam int STATE_W = 5;  // state number field width
  localparam int SYM_W   = 8;  // alphabet byte width
  localparam int SIDX_W  = 4;  // symbol_index field width
  localparam int OP_W    = 3;
  localparam int CFG_W   = 5;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TRANS = 3'd0,
    OP_LOAD_SYM   = 3'd1,
    OP_LOAD_MARK  = 3'd2,
    OP_CHAR       = 3'd3,
    OP_END_WORD   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // input item accepted this cycle
    logic step;    // table read data is valid, move current state
    logic finish;  // load the result register and close the word
  } dwa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_step;    // presented item needs a table step
    logic need_finish;  // presented item ends a word; used when it needs no step
    logic last_pending; // stepping item was the last character
    logic out_free;     // result register can take a new result
  } dwa_status_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] s, input int n);
    return (s != '0) && (32'(s) <= n);
  endfunction

endpackage

[sv/dwa_ctrl.sv]
// dwa_ctrl: sequencing state machine of the dfa word acceptor
// depends on dwa_pkg; drives dwa_datapath through dwa_cmd_t
module dwa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dwa_pkg::dwa_status_t  status,
  output dwa_pkg::dwa_cmd_t     cmd
);
  import dwa_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.need_step) begin
            state_next = ST_STEP;
          end else if (status.need_finish) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.last_pending ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[sv/dwa_datapath.sv]
// dwa_datapath: alphabet lanes, transition memory, accept marks, word state
// and result register of the dfa word acceptor; depends on dwa_pkg
module dwa_datapath #(
  parameter int NUM_STATES  = dwa_pkg::DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = dwa_pkg::DEF_NUM_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dwa_pkg::CFG_W-1:0]     cfg_data,
  input  logic [dwa_pkg::OP_W-1:0]      opcode,
  input  logic [dwa_pkg::STATE_W-1:0]   state_index,
  input  logic [dwa_pkg::SIDX_W-1:0]    symbol_index,
  input  logic [dwa_pkg::SYM_W-1:0]     char_code,
  input  logic [dwa_pkg::STATE_W-1:0]   next_state,
  input  logic                          accept_mark,
  input  logic                          last_char,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          accepted,
  output logic                          invalid_symbol,
  output logic [dwa_pkg::STATE_W-1:0]   end_state,
  input  dwa_pkg::dwa_cmd_t             cmd,
  output dwa_pkg::dwa_status_t          status
);
  import dwa_pkg::*;

  localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int IDX_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int MARK_W    = $clog2(NUM_STATES);

  logic [STATE_W-1:0] start_state;
  logic [CFG_W-1:0]   symbol_count;
  logic [STATE_W-1:0] cur;
  logic               in_word;
  logic               inv;
  logic               last_pending;
  logic [STATE_W-1:0] rdata;

  logic [SYM_W-1:0]   alphabet [NUM_SYMBOLS];
  logic [STATE_W-1:0] trans_mem [TBL_DEPTH];
  logic [NUM_STATES-1:0] marks;

  logic [STATE_W-1:0] eff_cur;
  logic               eff_inv;
  logic               match;
  logic [IDX_W-1:0]   match_idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_en;
  logic               sym_ok;
  logic               st_ok;
  logic               is_char;
  logic               res_accept;

  // word start takes the start state
  assign eff_cur = in_word ? cur : start_state;
  assign eff_inv = in_word && inv;

  // lowest matching alphabet lane among the symbols in use
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int j = NUM_SYMBOLS - 1; j >= 0; j--) begin
      if ((32'(j) < 32'(symbol_count)) && (alphabet[j] == char_code)) begin
        match     = 1'b1;
        match_idx = IDX_W'(j);
      end
    end
  end

  assign is_char = (opcode == OP_CHAR);
  assign sym_ok  = (32'(symbol_index) < NUM_SYMBOLS);
  assign st_ok   = state_ok(state_index, NUM_STATES);

  assign rd_addr = ADDR_W'((32'(eff_cur) - 32'd1) * NUM_SYMBOLS + 32'(match_idx));
  assign wr_addr = ADDR_W'((32'(state_index) - 32'd1) * NUM_SYMBOLS + 32'(symbol_index));
  assign wr_en   = cmd.take && (opcode == OP_LOAD_TRANS) && st_ok && sym_ok;

  assign status.need_step    = is_char && !eff_inv && match && state_ok(eff_cur, NUM_STATES);
  assign status.need_finish  = (is_char && last_char) || (opcode == OP_END_WORD);
  assign status.last_pending = last_pending;
  assign status.out_free     = !out_valid || !out_stall;

  assign res_accept = !inv && state_ok(cur, NUM_STATES) && marks[MARK_W'(cur - 5'd1)];

  // transition memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      trans_mem[wr_addr] <= next_state;
    end
    if (cmd.take && is_char) begin
      rdata <= trans_mem[rd_addr];
    end
  end

  // alphabet lanes
  always_ff @(posedge clk) begin
    if (cmd.take && (opcode == OP_LOAD_SYM) && sym_ok) begin
      alphabet[IDX_W'(symbol_index)] <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= STATE_W'(1);
      symbol_count <= '0;
      marks        <= '0;
      cur          <= STATE_W'(1);
      in_word      <= 1'b0;
      inv          <= 1'b0;
      last_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_START_STATE:  start_state  <= STATE_W'(cfg_data);
          CFG_SYMBOL_COUNT: symbol_count <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take && (opcode == OP_LOAD_MARK) && st_ok) begin
        marks[MARK_W'(state_index - 5'd1)] <= accept_mark;
      end
      if (cmd.take && is_char) begin
        in_word      <= 1'b1;
        cur          <= eff_cur;
        inv          <= eff_inv || !match;
        last_pending <= last_char;
      end
      if (cmd.take && (opcode == OP_END_WORD)) begin
        cur <= eff_cur;
        inv <= eff_inv;
      end
      if (cmd.step) begin
        cur <= rdata;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        in_word   <= 1'b0;
        inv       <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      accepted       <= res_accept;
      invalid_symbol <= inv;
      end_state      <= cur;
    end
  end

endmodule

[sv/dfa_word_acceptor.sv]
// dfa_word_acceptor: top level of the programmable table-driven dfa
// instantiates dwa_ctrl and dwa_datapath; depends on dwa_pkg
//
// usage
//   input channel: in_valid / in_stall with one item per accept; the opcode
//   selects a transition load, a symbol load, an accept-mark load, a word
//   character or an end-word item
//   output channel: out_valid / out_stall; one item per finished word with
//   accepted, invalid_symbol and end_state
//   configuration: cfg_write with cfg_index / cfg_data, taken at once;
//   index 0 is start_state, index 1 is symbol_count
// timing
//   loads and characters that do not move the state: one item per cycle
//   while the sequencer is idle
//   a character that moves the state passes through the step state, which
//   waits for the registered read of the transition memory
//   a word end passes through the finish state, which waits while the result
//   register is full and stalled, then registers out_valid and the result
// reset: rst clears control, accept marks, start_state to 1 and symbol_count
//   to 0; the alphabet and the transition memory are not cleared
// stall: a waiting result does not block loads or characters; only the next
//   word end waits until the result register is free
module dfa_word_acceptor #(
  parameter int NUM_STATES  = dwa_pkg::DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = dwa_pkg::DEF_NUM_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          cfg_write,
  input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dwa_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dwa_pkg::OP_W-1:0]      opcode,
  input  logic [dwa_pkg::STATE_W-1:0]   state_index,
  input  logic [dwa_pkg::SIDX_W-1:0]    symbol_index,
  input  logic [dwa_pkg::SYM_W-1:0]     char_code,
  input  logic [dwa_pkg::STATE_W-1:0]   next_state,
  input  logic                          accept_mark,
  input  logic                          last_char,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic                          invalid_symbol,
  output logic [dwa_pkg::STATE_W-1:0]   end_state
);
  import dwa_pkg::*;

  // command and status between sequencer and datapath
  dwa_cmd_t    cmd;
  dwa_status_t status;

  // sequencer: idle takes items, step waits for the table read,
  // finish waits for a free result register
  dwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, alphabet match, table memory, word state, result register
  dwa_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .state_index    (state_index),
    .symbol_index   (symbol_index),
    .char_code      (char_code),
    .next_state     (next_state),
    .accept_mark    (accept_mark),
    .last_char      (last_char),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .accepted       (accepted),
    .invalid_symbol (invalid_symbol),
    .end_state      (end_state),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

[sv/dwa_checker.sv]
// dwa_checker: port-level assertions for dfa_word_acceptor
// depends on dwa_pkg; bound to the top level below
module dwa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [dwa_pkg::OP_W-1:0]      opcode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          accepted,
  input logic                          invalid_symbol,
  input logic [dwa_pkg::STATE_W-1:0]   end_state
);
  import dwa_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // an accepted word never carries the invalid flag
  a_acc_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !invalid_symbol)
    else $error("accepted word flagged invalid");

  // an accepted word ends in a real state
  a_acc_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> end_state != '0)
    else $error("accepted word in state zero");

  // an end-word item always enters the finish state to build its result
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_END_WORD |=> in_stall)
    else $error("end-word item did not enter finish");

endmodule

bind dfa_word_acceptor dwa_checker u_dwa_checker (.*);
